// ===== hw/rtl/bpeq_pkg.sv =====
// ----------------------------------------------------------------------------
// bpeq_pkg
// shared types and codes for the bounded priority event queue core
// ----------------------------------------------------------------------------
package bpeq_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_DISABLED = 2'd3
  } status_t;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_ENABLE   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WALK,
    S_PLACE,
    S_POP,
    S_DONE
  } fsm_t;

endpackage

// ===== hw/rtl/bpeq_ram.sv =====
// ----------------------------------------------------------------------------
// bpeq_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module bpeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/bounded_priority_event_queue_core.sv =====
// bounded priority event queue core
// path: clear, nop and disabled queues go READ then DONE; a get goes READ,
//   POP, DONE (READ then DONE when empty); an add goes READ, WALK over the
//   entries (skipped for an empty queue), PLACE, DONE, or WALK straight to DONE
// one item at a time: the next item can be taken in the cycle after its result
//   enters the output register
// reset: synchronous; counts zero, capacity 16, all queues disabled
// ----------------------------------------------------------------------------
// bounded_priority_event_queue_core
// per-queue sorted insertion with drop-lowest, entries kept in one ram
// ----------------------------------------------------------------------------
module bounded_priority_event_queue_core #(
  parameter int NUM_QUEUES  = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // slave: command[1:0], queue_index[5:2], event_priority[13:6], poster_id[23:14]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,
  // master: status[1:0], out_priority[9:2], out_poster_id[19:10], occupancy[24:20]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import bpeq_pkg::*;

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int DW = $clog2(QUEUE_DEPTH);
  localparam int AW = QW + DW;
  localparam int ENTRIES = 1 << AW;
  localparam int NE = (NUM_QUEUES < 16) ? NUM_QUEUES : 16;
  localparam int CW = DW + 1;

  // config registers
  logic [4:0]  capacity;
  logic [15:0] enable_mask;
  logic [CW-1:0] count [NUM_QUEUES];

  // item registers
  fsm_t state, state_next;
  cmd_t cmd;
  logic [3:0] qraw;
  logic [QW-1:0] q;
  logic [7:0] pr;
  logic [9:0] pid;
  logic [CW-1:0] n, cap_eff, pos;   // pos: walk index
  logic full;
  logic [1:0] st;
  logic [7:0] opr;
  logic [9:0] oid;
  logic [4:0] occ;
  logic       found;

  // ram
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [17:0]   wdata, rdata;

  bpeq_ram #(.WIDTH(18), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // output register lets the next item in while a result waits
  logic out_full;
  logic out_load;
  assign cfg_ready = (state == S_IDLE);
  assign s_tready  = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_full || m_tready);

  logic q_valid, q_en;
  assign q_valid = ({3'b0, qraw} < 7'(NUM_QUEUES));
  assign q_en    = q_valid && ({1'b0, qraw} < 5'(NE)) && enable_mask[qraw];

  logic [7:0] rd_pr;
  assign rd_pr = rdata[7:0];

  // occupancy of addressed queue for the result
  logic [CW-1:0] cnt_q, cnt_inc, cnt_dec, pos_inc, pos_dec;
  logic          full_now;
  assign cnt_q    = q_valid ? count[q] : '0;
  assign cnt_inc  = cnt_q + 1'b1;
  assign cnt_dec  = cnt_q - 1'b1;
  assign pos_inc  = pos + 1'b1;
  assign pos_dec  = pos - 1'b1;
  assign full_now = (cnt_q >= cap_eff);

  // walk: full add walks up from 0 (entry e moves to e-1 while below pr);
  // room add walks down from n-1 (entry moves to e+1 while >= pr).
  // ram read of the next entry issued in the cycle before its data is examined
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid && s_tready) state_next = S_READ;
      S_READ: begin
        if (!q_en || cmd == CMD_CLEAR || cmd == CMD_NOP) state_next = S_DONE;
        else if (cmd == CMD_GET) state_next = (cnt_q != '0) ? S_POP : S_DONE;
        else state_next = (cnt_q != '0) ? S_WALK : S_PLACE;
      end
      S_WALK: begin
        if (full) begin
          if (rd_pr >= pr) state_next = S_DONE;
          else if (pos == n - 1'b1) state_next = S_PLACE;
        end else begin
          if (rd_pr < pr) state_next = S_DONE;
          else if (pos == '0) state_next = S_PLACE;
        end
      end
      S_PLACE: state_next = S_DONE;
      S_POP:   state_next = S_DONE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ram address and write control
  always_comb begin
    we    = 1'b0;
    waddr = {q, pos[DW-1:0]};
    wdata = {pid, pr};
    raddr = {q, pos[DW-1:0]};
    case (state)
      S_READ: begin
        // full add starts at the lowest entry, everything else at the top
        if (cmd == CMD_ADD && full_now) raddr = {q, {DW{1'b0}}};
        else raddr = {q, cnt_dec[DW-1:0]};
      end
      S_WALK: begin
        if (full) begin
          raddr = {q, pos_inc[DW-1:0]};
          if (rd_pr < pr) begin
            if (pos != '0) begin
              we    = 1'b1;
              waddr = {q, pos_dec[DW-1:0]};
              wdata = rdata;
            end
          end else if (found) begin
            // new entry lands just below the first entry it does not beat
            we    = 1'b1;
            waddr = {q, pos_dec[DW-1:0]};
          end
        end else begin
          raddr = {q, pos_dec[DW-1:0]};
          we    = 1'b1;
          waddr = {q, pos_inc[DW-1:0]};
          if (rd_pr >= pr) wdata = rdata;
        end
      end
      S_PLACE: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      capacity    <= 5'd16;
      enable_mask <= '0;
      out_full    <= 1'b0;
      m_tdata     <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) count[i] <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_full <= 1'b1;
        m_tdata  <= {7'b0, occ, oid, opr, st};
      end else if (m_tvalid && m_tready) begin
        out_full <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CAPACITY) begin
          capacity <= cfg_data[4:0];
        end else begin
          for (int i = 0; i < NE; i++) begin
            if (cfg_data[i] && !enable_mask[i]) count[i] <= '0;
          end
          enable_mask <= cfg_data;
        end
      end
      case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          cmd  <= cmd_t'(s_tdata[1:0]);
          qraw <= s_tdata[5:2];
          q    <= QW'(s_tdata[5:2]);
          pr   <= s_tdata[13:6];
          pid  <= s_tdata[23:14];
        end
        S_READ: begin
          n     <= cnt_q;
          full  <= full_now;
          found <= 1'b0;
          st    <= ST_OK;
          opr   <= '0;
          oid   <= '0;
          occ   <= 5'(cnt_q);
          if (cmd == CMD_ADD && (full_now || cnt_q == '0)) pos <= '0;
          else pos <= cnt_dec;
          if (!q_en && cmd != CMD_NOP) begin
            st <= ST_DISABLED;
          end else begin
            case (cmd)
              CMD_ADD: begin
                if (!full_now) begin
                  count[q] <= cnt_inc;
                  occ      <= 5'(cnt_inc);
                end
              end
              CMD_GET: begin
                if (cnt_q == '0) st <= ST_EMPTY;
                else begin
                  count[q] <= cnt_dec;
                  occ      <= 5'(cnt_dec);
                end
              end
              CMD_CLEAR: begin
                count[q] <= '0;
                occ      <= '0;
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (full) begin
            if (rd_pr < pr) begin
              found <= 1'b1;
              if (pos != n - 1'b1) pos <= pos_inc;
            end else if (!found) begin
              st <= ST_DROPPED;
            end
          end else if (rd_pr >= pr && pos != '0) begin
            pos <= pos_dec;
          end
        end
        S_POP: begin
          opr <= rdata[7:0];
          oid <= rdata[17:8];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cap_eff = CW'(QUEUE_DEPTH);
    if (capacity == 5'd0) cap_eff = CW'(1);
    else if ({2'b0, capacity} < 7'(QUEUE_DEPTH)) cap_eff = CW'(capacity);
  end

  assign m_tvalid = out_full;

endmodule

// ===== hw/rtl/bpeq_checker.sv =====
// ----------------------------------------------------------------------------
// bpeq_checker
// port-level checks for the event queue core
// ----------------------------------------------------------------------------
module bpeq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output not held");
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("second item taken while busy");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tdata[19:2] == 18'd0) else $error("payload on error");
  a_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[24:20] <= 5'd16) else $error("occupancy too large");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> s_tready) else $error("config taken while busy");
endmodule

bind bounded_priority_event_queue_core bpeq_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .cfg_ready(cfg_ready)
);
